[rtl/core/orb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types and constants for the overwriting ring buffer.
// ----------------------------------------------------------------------------
package orb_pkg;

    localparam int LEN_W  = 7;
    localparam int KIND_W = 3;
    localparam int AGE_W  = 6;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH      = 3'd0,
        K_POP       = 3'd1,
        K_PEEK_OLD  = 3'd2,
        K_PEEK_NEW  = 3'd3,
        K_READ_AGE  = 3'd4,
        K_CLEAR     = 3'd5
    } t_kind;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DONE = 1'b1
    } t_state;

    typedef struct packed {
        logic step;
        logic load;
    } t_cmd;

endpackage

[rtl/core/overwriting_ring_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer
// Ring buffer of words that discards its oldest entry when pushed while full.
// ----------------------------------------------------------------------------
// Each transaction first updates the pointers and issues the store access,
// then waits for the registered read of the entry store to return. A
// new transaction is accepted as soon as the previous result has moved into
// the output register, so a stalled consumer holds at most one finished
// result plus one in progress. Writing capacity empties the buffer; write it
// only while no transaction is outstanding.
module overwriting_ring_buffer #(
    parameter int MAX_DEPTH = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [orb_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [orb_pkg::KIND_W-1:0]  i_kind,
    input  logic [WORD_BITS-1:0]        i_value,
    input  logic [orb_pkg::AGE_W-1:0]   i_age_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_ok,
    output logic [WORD_BITS-1:0]        o_data,
    output logic [orb_pkg::LEN_W-1:0]   o_length,
    output logic                        o_is_full,
    output logic                        o_is_empty,
    output logic                        o_overwrote
);

    orb_pkg::t_cmd w_cmd;

    orb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    orb_dp #(
        .MAX_DEPTH (MAX_DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .i_age_index (i_age_index),
        .o_ok        (o_ok),
        .o_data      (o_data),
        .o_length    (o_length),
        .o_is_full   (o_is_full),
        .o_is_empty  (o_is_empty),
        .o_overwrote (o_overwrote)
    );

endmodule

[rtl/core/orb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/orb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ctrl
// Transaction sequencer: accepts an operation, waits for the store read,
// then hands the result to the output register once that register is free.
// ----------------------------------------------------------------------------
module orb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output orb_pkg::t_cmd o_cmd
);

    orb_pkg::t_state r_state;
    orb_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            orb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = orb_pkg::S_DONE;
                end
            end
            orb_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_state = orb_pkg::S_IDLE;
                end
            end
            default: n_state = orb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            orb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.step = i_in_valid;
            end
            orb_pkg::S_DONE: begin
                o_cmd.load = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_step_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == orb_pkg::S_DONE && !o_in_ready))
        else $error("accepted transaction did not enter completion state");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("loaded result not presented");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before acceptance");

endmodule

[rtl/core/orb_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_dp
// Datapath: capacity register, ring pointers, entry count, entry store,
// and result registers.
// ----------------------------------------------------------------------------
module orb_dp #(
    parameter int MAX_DEPTH = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  orb_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_we,
    input  logic [orb_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic [orb_pkg::KIND_W-1:0]  i_kind,
    input  logic [WORD_BITS-1:0]        i_value,
    input  logic [orb_pkg::AGE_W-1:0]   i_age_index,
    output logic                        o_ok,
    output logic [WORD_BITS-1:0]        o_data,
    output logic [orb_pkg::LEN_W-1:0]   o_length,
    output logic                        o_is_full,
    output logic                        o_is_empty,
    output logic                        o_overwrote
);

    localparam int PW      = $clog2(MAX_DEPTH);
    localparam int LW      = orb_pkg::LEN_W;
    localparam int XW      = ((PW > LW) ? PW : LW) + 1;
    localparam int CAP_MAX = (MAX_DEPTH < 127) ? MAX_DEPTH : 127;
    localparam int CAP_RST = (MAX_DEPTH < 64) ? MAX_DEPTH : 64;

    logic [LW-1:0]        r_capacity;
    logic [PW-1:0]        r_oldest;
    logic [PW-1:0]        r_wp;
    logic [LW-1:0]        r_count;

    logic [PW-1:0]        n_oldest;
    logic [PW-1:0]        n_wp;
    logic [LW-1:0]        n_count;
    logic                 n_ok;
    logic                 n_rd;
    logic                 n_over;

    logic                 r_p_ok;
    logic                 r_p_rd;
    logic                 r_p_over;
    logic [LW-1:0]        r_p_len;
    logic                 r_p_full;
    logic                 r_p_empty;

    logic                 r_ok;
    logic [WORD_BITS-1:0] r_data;
    logic [LW-1:0]        r_len;
    logic                 r_full;
    logic                 r_empty;
    logic                 r_over;

    logic [LW-1:0]        w_cap;
    logic [PW-1:0]        w_newest;
    logic [XW-1:0]        w_age_sum;
    logic [PW-1:0]        w_age_ptr;
    logic [PW-1:0]        w_raddr;
    logic                 w_we;
    logic                 w_re;
    logic [WORD_BITS-1:0] w_rdata;
    orb_pkg::t_kind       w_kind;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [LW-1:0] cap);
        logic [XW-1:0] n;
        n = XW'(p) + XW'(1);
        return (n >= XW'(cap)) ? '0 : PW'(n);
    endfunction

    always_comb begin
        if (r_capacity == '0) begin
            w_cap = LW'(1);
        end else if (int'(r_capacity) > CAP_MAX) begin
            w_cap = LW'(CAP_MAX);
        end else begin
            w_cap = r_capacity;
        end
    end

    assign w_kind    = orb_pkg::t_kind'(i_kind);
    assign w_newest  = (r_wp == '0) ? PW'(w_cap - LW'(1)) : r_wp - PW'(1);
    assign w_age_sum = XW'(r_wp) + XW'(w_cap) - XW'(1) - XW'(i_age_index);
    assign w_age_ptr = (w_age_sum >= XW'(w_cap)) ? PW'(w_age_sum - XW'(w_cap))
                                                 : PW'(w_age_sum);

    always_comb begin
        n_oldest = r_oldest;
        n_wp     = r_wp;
        n_count  = r_count;
        n_ok     = 1'b0;
        n_rd     = 1'b0;
        n_over   = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_raddr  = r_oldest;
        case (w_kind)
            orb_pkg::K_PUSH: begin
                if (r_count >= w_cap) begin
                    n_oldest = adv(r_oldest, w_cap);
                    n_over   = 1'b1;
                end else begin
                    n_count = r_count + LW'(1);
                end
                w_we = 1'b1;
                n_wp = adv(r_wp, w_cap);
                n_ok = 1'b1;
            end
            orb_pkg::K_POP: begin
                if (r_count != '0) begin
                    w_re     = 1'b1;
                    n_oldest = adv(r_oldest, w_cap);
                    n_count  = r_count - LW'(1);
                    n_ok     = 1'b1;
                    n_rd     = 1'b1;
                end
            end
            orb_pkg::K_PEEK_OLD: begin
                if (r_count != '0) begin
                    w_re = 1'b1;
                    n_ok = 1'b1;
                    n_rd = 1'b1;
                end
            end
            orb_pkg::K_PEEK_NEW: begin
                if (r_count != '0) begin
                    w_re    = 1'b1;
                    w_raddr = w_newest;
                    n_ok    = 1'b1;
                    n_rd    = 1'b1;
                end
            end
            orb_pkg::K_READ_AGE: begin
                if (LW'(i_age_index) < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = w_age_ptr;
                    n_ok    = 1'b1;
                    n_rd    = 1'b1;
                end
            end
            orb_pkg::K_CLEAR: begin
                n_oldest = '0;
                n_wp     = '0;
                n_count  = '0;
                n_ok     = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    orb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.step && w_we),
        .i_waddr (r_wp),
        .i_wdata (i_value),
        .i_re    (i_cmd.step && w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LW'(CAP_RST);
            r_oldest   <= '0;
            r_wp       <= '0;
            r_count    <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
            r_oldest   <= '0;
            r_wp       <= '0;
            r_count    <= '0;
        end else if (i_cmd.step) begin
            r_oldest <= n_oldest;
            r_wp     <= n_wp;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_p_ok    <= n_ok;
            r_p_rd    <= n_rd;
            r_p_over  <= n_over;
            r_p_len   <= n_count;
            r_p_full  <= (n_count == w_cap);
            r_p_empty <= (n_count == '0);
        end
        if (i_cmd.load) begin
            r_ok    <= r_p_ok;
            r_data  <= r_p_rd ? w_rdata : '0;
            r_len   <= r_p_len;
            r_full  <= r_p_full;
            r_empty <= r_p_empty;
            r_over  <= r_p_over;
        end
    end

    assign o_ok        = r_ok;
    assign o_data      = r_data;
    assign o_length    = r_len;
    assign o_is_full   = r_full;
    assign o_is_empty  = r_empty;
    assign o_overwrote = r_over;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_cap)
        else $error("entry count exceeds capacity");

    a_oldest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_oldest) < XW'(w_cap))
        else $error("oldest pointer out of range");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_wp) < XW'(w_cap))
        else $error("write pointer out of range");

endmodule
